// ===== rtl/tlmmr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlmmr_pkg
// shared constants and types for the two-level min/max/rms summary
// ----------------------------------------------------------------------------
package tlmmr_pkg;

    localparam int FRAME_SAMPLES    = 256;
    localparam int FRAMES_PER_GROUP = 256;
    localparam int FRAME_LOG2       = 8;
    localparam int GROUP_LOG2       = 8;

    localparam logic [38:0] SUMSQ39_MAX = {39{1'b1}};
    localparam logic [50:0] SUMSQ51_MAX = {51{1'b1}};
    localparam logic [20:0] COUNT21_MAX = {21{1'b1}};
    localparam logic [15:0] RMS_MAX     = 16'd32768;

    localparam logic [1:0] LEVEL_FRAME = 2'd0;
    localparam logic [1:0] LEVEL_GROUP = 2'd1;
    localparam logic [1:0] LEVEL_BLOCK = 2'd2;

    // one closed span handed from the front end to the back end
    typedef struct packed {
        logic [1:0]  level;
        logic [15:0] min_value;
        logic [15:0] max_value;
        logic [59:0] num;       // dividend
        logic [28:0] den;       // divisor, at least 1
        logic        block_end;
    } job_t;

    // one finished result
    typedef struct packed {
        logic [1:0]  level;
        logic [15:0] min_value;
        logic [15:0] max_value;
        logic [15:0] rms_value;
        logic        block_end;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/tlmmr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlmmr_front
// accumulates sample stats, emits frame and block jobs; group jobs are built
// once the frame rms comes back from the back end
// ----------------------------------------------------------------------------
module tlmmr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [15:0]       sample,
    input  wire logic              last,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output tlmmr_pkg::job_t        job,
    input  wire logic              frms_valid,
    input  wire logic [15:0]       frms
);

    typedef enum logic [4:0] {
        ST_RUN   = 5'b00001,
        ST_FRAME = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_GROUP = 5'b01000,
        ST_BLOCK = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic signed [15:0] fmin_reg, fmax_reg, gmin_reg, gmax_reg, bmin_reg, bmax_reg;
    logic [38:0] fsum_reg, gsum_reg;
    logic [50:0] bsum_reg;
    logic [8:0]  fcnt_reg, gcnt_reg;
    logic [20:0] bcnt_reg;
    logic [8:0]  lastcnt_reg;
    logic        last_reg;
    logic        gclose_reg;

    logic signed [15:0] s;
    logic [15:0] mag;
    logic [31:0] sq;
    logic [39:0] fsum_add;
    logic [51:0] bsum_add;
    logic [39:0] gsum_add;
    logic [31:0] fsq;
    logic        take;

    assign s        = signed'(sample);
    assign mag      = s[15] ? 16'(-s) : s;
    assign sq       = mag * mag;
    assign fsum_add = {1'b0, fsum_reg} + {8'd0, sq};
    assign bsum_add = {1'b0, bsum_reg} + {20'd0, sq};
    assign fsq      = frms * frms;
    assign gsum_add = {1'b0, gsum_reg} + {8'd0, fsq};
    assign in_ready = (state_reg == ST_RUN);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        job       = '0;
        job_valid = 1'b0;
        case (state_reg)
            ST_FRAME:
            begin
                job_valid     = 1'b1;
                job.level     = tlmmr_pkg::LEVEL_FRAME;
                job.min_value = fmin_reg;
                job.max_value = fmax_reg;
                job.num       = {21'd0, fsum_reg};
                job.den       = {20'd0, lastcnt_reg};
            end
            ST_GROUP:
            begin
                job_valid     = 1'b1;
                job.level     = tlmmr_pkg::LEVEL_GROUP;
                job.min_value = gmin_reg;
                job.max_value = gmax_reg;
                if (last_reg)
                begin
                    job.num = {13'd0, gsum_reg, 8'd0};
                    job.den = {12'd0, gcnt_reg - 9'd1, 8'd0} + {20'd0, lastcnt_reg};
                end
                else
                begin
                    job.num = {29'd0, gsum_reg[38:8]};
                    job.den = 29'd1;
                end
            end
            ST_BLOCK:
            begin
                job_valid     = 1'b1;
                job.level     = tlmmr_pkg::LEVEL_BLOCK;
                job.min_value = bmin_reg;
                job.max_value = bmax_reg;
                job.num       = {9'd0, bsum_reg};
                job.den       = {8'd0, bcnt_reg};
                job.block_end = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
                if (take)
                begin
                    if (fcnt_reg == 9'(tlmmr_pkg::FRAME_SAMPLES - 1) || last)
                        state_next = ST_FRAME;
                    else if (last)
                        state_next = ST_BLOCK;
                end
            ST_FRAME: if (job_ready) state_next = ST_WAIT;
            ST_WAIT:
                if (frms_valid)
                    state_next = gclose_reg ? ST_GROUP : (last_reg ? ST_BLOCK : ST_RUN);
            ST_GROUP: if (job_ready) state_next = last_reg ? ST_BLOCK : ST_RUN;
            ST_BLOCK: if (job_ready) state_next = ST_RUN;
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RUN;
            fcnt_reg    <= '0;
            gcnt_reg    <= '0;
            bcnt_reg    <= '0;
            fsum_reg    <= '0;
            gsum_reg    <= '0;
            bsum_reg    <= '0;
            fmin_reg    <= '0;
            fmax_reg    <= '0;
            gmin_reg    <= '0;
            gmax_reg    <= '0;
            bmin_reg    <= '0;
            bmax_reg    <= '0;
            lastcnt_reg <= '0;
            last_reg    <= 1'b0;
            gclose_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                if (fcnt_reg == 9'd0 || s < fmin_reg) fmin_reg <= s;
                if (fcnt_reg == 9'd0 || s > fmax_reg) fmax_reg <= s;
                if (bcnt_reg == 21'd0 || s < bmin_reg) bmin_reg <= s;
                if (bcnt_reg == 21'd0 || s > bmax_reg) bmax_reg <= s;
                fsum_reg <= fsum_add[39] ? tlmmr_pkg::SUMSQ39_MAX : fsum_add[38:0];
                bsum_reg <= bsum_add[51] ? tlmmr_pkg::SUMSQ51_MAX : bsum_add[50:0];
                if (bcnt_reg != tlmmr_pkg::COUNT21_MAX) bcnt_reg <= bcnt_reg + 21'd1;
                lastcnt_reg <= fcnt_reg + 9'd1;
                last_reg    <= last;
                if (fcnt_reg == 9'(tlmmr_pkg::FRAME_SAMPLES - 1) || last)
                    fcnt_reg <= '0;
                else
                    fcnt_reg <= fcnt_reg + 9'd1;
            end
            if (state_reg == ST_FRAME && job_ready)
            begin
                // fold frame min/max into the group now, rms arrives later
                if (gcnt_reg == 9'd0 || fmin_reg < gmin_reg) gmin_reg <= fmin_reg;
                if (gcnt_reg == 9'd0 || fmax_reg > gmax_reg) gmax_reg <= fmax_reg;
                gcnt_reg   <= gcnt_reg + 9'd1;
                gclose_reg <= (gcnt_reg == 9'(tlmmr_pkg::FRAMES_PER_GROUP - 1)) || last_reg;
                fsum_reg   <= '0;
            end
            if (state_reg == ST_WAIT && frms_valid)
                gsum_reg <= gsum_add[39] ? tlmmr_pkg::SUMSQ39_MAX : gsum_add[38:0];
            if (state_reg == ST_GROUP && job_ready)
            begin
                gcnt_reg <= '0;
                gsum_reg <= '0;
            end
            if (state_reg == ST_BLOCK && job_ready)
            begin
                bcnt_reg <= '0;
                bsum_reg <= '0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tlmmr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlmmr_back
// one-deep job queue, serial divider and serial square root, output register
// ----------------------------------------------------------------------------
module tlmmr_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  wire tlmmr_pkg::job_t   job,
    output logic                   frms_valid,
    output logic [15:0]            frms,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output tlmmr_pkg::res_t        res
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_DIV  = 4'b0010,
        B_SQRT = 4'b0100,
        B_OUT  = 4'b1000
    } bstate_t;

    bstate_t bst_reg;
    tlmmr_pkg::job_t q_reg;
    logic        q_valid_reg;
    logic [59:0] quo_reg;
    logic [29:0] rem_reg;
    logic [5:0]  step_reg;
    logic [31:0] root_reg;
    logic [33:0] srem_reg;
    logic [4:0]  sstep_reg;
    logic        res_valid_reg;
    tlmmr_pkg::res_t res_reg;

    logic [29:0] rem_sh;
    logic [29:0] rem_sub;
    logic [33:0] srem_sh;
    logic [33:0] trial;
    logic [15:0] rms_sat;

    assign job_ready = !q_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign rem_sh    = {rem_reg[28:0], quo_reg[59]};
    assign rem_sub   = rem_sh - {1'b0, q_reg.den};
    assign srem_sh   = {srem_reg[31:0], quo_reg[59:58]};
    assign trial     = {root_reg, 2'b01};
    assign rms_sat   = (root_reg > {16'd0, tlmmr_pkg::RMS_MAX}) ? tlmmr_pkg::RMS_MAX
                                                               : root_reg[15:0];
    assign frms_valid = (bst_reg == B_OUT) && !res_valid_reg
                        && q_reg.level == tlmmr_pkg::LEVEL_FRAME;
    assign frms       = rms_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bst_reg       <= B_IDLE;
            q_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
            if (job_valid && job_ready)
            begin
                q_reg       <= job;
                q_valid_reg <= 1'b1;
            end
            case (bst_reg)
                B_IDLE:
                    if (q_valid_reg)
                    begin
                        quo_reg  <= q_reg.num;
                        rem_reg  <= '0;
                        step_reg <= '0;
                        bst_reg  <= B_DIV;
                    end
                B_DIV:
                begin
                    // restoring division, one quotient bit a beat
                    if (!rem_sub[29])
                    begin
                        rem_reg <= rem_sub;
                        quo_reg <= {quo_reg[58:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[58:0], 1'b0};
                    end
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd59)
                    begin
                        root_reg  <= '0;
                        srem_reg  <= '0;
                        sstep_reg <= '0;
                        bst_reg   <= B_SQRT;
                    end
                end
                B_SQRT:
                begin
                    // digit-by-digit root, two radicand bits a beat
                    quo_reg <= {quo_reg[57:0], 2'b00};
                    if (srem_sh >= trial)
                    begin
                        srem_reg <= srem_sh - trial;
                        root_reg <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= srem_sh;
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    sstep_reg <= sstep_reg + 5'd1;
                    if (sstep_reg == 5'd29) bst_reg <= B_OUT;
                end
                B_OUT:
                    if (!res_valid_reg)
                    begin
                        res_reg.level     <= q_reg.level;
                        res_reg.min_value <= q_reg.min_value;
                        res_reg.max_value <= q_reg.max_value;
                        res_reg.rms_value <= rms_sat;
                        res_reg.block_end <= q_reg.block_end;
                        res_valid_reg     <= 1'b1;
                        q_valid_reg       <= 1'b0;
                        bst_reg           <= B_IDLE;
                    end
                default: bst_reg <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/two_level_min_max_rms_summary.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_min_max_rms_summary
// frame, group and block min/max/rms of an audio sample stream
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one sample beat, tlast on the block's last sample.
//   m_axis carries result beats: a frame result every 256 samples or at
//   tlast, then a group result when 256 frames close or at tlast, then the
//   block result at tlast with tuser[2] set.
//   a sample that does not close a frame leaves the input ready for the next sample.
//   each result goes through a 60-step serial divider and a 30-step serial
//   square root between job pickup and output write; the back end takes no
//   new job until the result is written out.
//   a sample that closes a frame holds the input until the frame rms
//   returns; a group close then holds it until the group job is taken, and at
//   tlast the block job waits behind the group job.
//   a stalled m_axis holds the result in the output register; the back end
//   and then the input stall behind it.
//   reset empties all accumulators and drops any result in flight.
// ----------------------------------------------------------------------------
module two_level_min_max_rms_summary (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // sample
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // min_value, max_value, rms_value
    output logic [2:0]       m_axis_tuser    // level, block_end
);

    logic            job_valid, job_ready, frms_valid;
    logic [15:0]     frms;
    tlmmr_pkg::job_t job;
    tlmmr_pkg::res_t res;

    tlmmr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .sample     (s_axis_tdata),
        .last       (s_axis_tlast),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .frms_valid (frms_valid),
        .frms       (frms)
    );

    tlmmr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .frms_valid (frms_valid),
        .frms       (frms),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    assign m_axis_tdata = {res.rms_value, res.max_value, res.min_value};
    assign m_axis_tuser = {res.block_end, res.level};

    a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:32] <= tlmmr_pkg::RMS_MAX)
        else $error("rms out of range");

    a_end_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == tlmmr_pkg::LEVEL_BLOCK)
        else $error("block end on non-block result");

    a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= $signed(m_axis_tdata[31:16]))
        else $error("min above max");

endmodule
`default_nettype wire
